FILE: rtl/core/mcmp_pkg.sv
package mcmp_pkg;

  localparam logic [7:0] RealtimeMin  = 8'hF8;
  localparam logic [7:0] SysexStart   = 8'hF0;
  localparam logic [7:0] SysexEnd     = 8'hF7;
  localparam logic [7:0] ChanMin      = 8'h80;
  localparam logic [7:0] ChanMax      = 8'hEF;
  localparam logic [7:0] NoStatus     = 8'h00;
  localparam logic [3:0] HiProgram    = 4'hC;
  localparam logic [3:0] HiChanPress  = 4'hD;
  localparam logic [3:0] HiPitchBend  = 4'hE;

  typedef enum logic [2:0] {
    MsgNoteOff    = 3'd0,
    MsgNoteOn     = 3'd1,
    MsgPolyPress  = 3'd2,
    MsgControl    = 3'd3,
    MsgProgram    = 3'd4,
    MsgChanPress  = 3'd5,
    MsgPitchBend  = 3'd6,
    MsgSystem     = 3'd7
  } msg_type_e;

  typedef struct packed {
    msg_type_e   msg_type;
    logic [4:0]  channel;
    logic [6:0]  first_value;
    logic [6:0]  second_value;
    logic [13:0] bend_value;
  } result_t;

  function automatic result_t make_result(logic [7:0] status, logic [6:0] d1,
                                          logic [6:0] d2);
    result_t r;
    r.msg_type     = msg_type_e'(status[6:4]);
    r.channel      = {1'b0, status[3:0]} + 5'd1;
    r.first_value  = d1;
    r.second_value = d2;
    r.bend_value   = '0;
    unique case (status[6:4])
      MsgProgram, MsgChanPress: begin
        r.second_value = '0;
      end
      MsgPitchBend: begin
        r.bend_value   = {d2, d1};
        r.first_value  = '0;
        r.second_value = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/midi_channel_message_parser_unit.sv
// MIDI channel message parser with running status. One received byte enters per
// transaction on the input channel (in_valid_i / in_stall_o); every completed
// channel message leaves as one transaction on the output channel, with its
// type, channel 1..16, data values and a 14-bit pitch bend value. Real-time
// bytes (0xF8..0xFF) are ignored anywhere; SysEx data and data bytes without
// an active status are dropped. A byte is taken every cycle: decode is one
// pass of logic from the byte and the status registers into the result
// register or the skid entry behind it; that one-entry skid buffer keeps the
// input open while a result waits, so the input stalls only once both hold.
module midi_channel_message_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  msg_type_o,
  output logic [4:0]  channel_o,
  output logic [6:0]  first_value_o,
  output logic [6:0]  second_value_o,
  output logic [13:0] bend_value_o
);

  logic [7:0] status_q, status_d;
  logic [6:0] first_data_q, first_data_d;
  logic       fdv_q, fdv_d;

  logic              out_valid_q, out_valid_d;
  mcmp_pkg::result_t out_q, out_d;
  logic              sk_valid_q, sk_valid_d;
  mcmp_pkg::result_t sk_q, sk_d;

  logic              accept;
  logic              emit;
  mcmp_pkg::result_t res;
  logic              chan_active;
  logic              one_byte;
  logic              out_free;

  assign in_stall_o = sk_valid_q;
  assign accept     = in_valid_i && !sk_valid_q;

  assign chan_active = (status_q >= mcmp_pkg::ChanMin) && (status_q <= mcmp_pkg::ChanMax);
  assign one_byte    = (status_q[7:4] == mcmp_pkg::HiProgram) ||
                       (status_q[7:4] == mcmp_pkg::HiChanPress);

  always_comb begin
    status_d     = status_q;
    first_data_d = first_data_q;
    fdv_d        = fdv_q;
    emit         = 1'b0;
    res          = mcmp_pkg::make_result(status_q, first_data_q, rx_byte_i[6:0]);
    if (accept) begin
      priority if (rx_byte_i >= mcmp_pkg::RealtimeMin) begin
      end else if (rx_byte_i[7]) begin
        fdv_d = 1'b0;
        if (rx_byte_i <= mcmp_pkg::ChanMax || rx_byte_i == mcmp_pkg::SysexStart) begin
          status_d = rx_byte_i;
        end else begin
          status_d = mcmp_pkg::NoStatus;
        end
      end else if (!chan_active) begin
      end else if (one_byte) begin
        fdv_d = 1'b0;
        emit  = 1'b1;
        res   = mcmp_pkg::make_result(status_q, rx_byte_i[6:0], 7'd0);
      end else if (!fdv_q) begin
        first_data_d = rx_byte_i[6:0];
        fdv_d        = 1'b1;
      end else begin
        fdv_d = 1'b0;
        emit  = 1'b1;
      end
    end
  end

  // result register with skid entry behind it
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sk_valid_d  = sk_valid_q;
    sk_d        = sk_q;
    if (out_free) begin
      if (sk_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = sk_q;
        sk_valid_d  = emit;
        sk_d        = res;
      end else begin
        out_valid_d = emit;
        out_d       = res;
      end
    end else if (emit) begin
      sk_valid_d = 1'b1;
      sk_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= mcmp_pkg::NoStatus;
      fdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      status_q    <= status_d;
      fdv_q       <= fdv_d;
      out_valid_q <= out_valid_d;
      sk_valid_q  <= sk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_data_q <= first_data_d;
    out_q        <= out_d;
    sk_q         <= sk_d;
  end

  assign out_valid_o    = out_valid_q;
  assign msg_type_o     = out_q.msg_type;
  assign channel_o      = out_q.channel;
  assign first_value_o  = out_q.first_value;
  assign second_value_o = out_q.second_value;
  assign bend_value_o   = out_q.bend_value;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_fdv_two_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fdv_q |-> (chan_active && !one_byte))
    else $error("buffered data byte without a two-byte channel status");

  a_realtime_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rx_byte_i >= mcmp_pkg::RealtimeMin) |=> ($stable(status_q) && $stable(fdv_q)))
    else $error("real-time byte changed parser state");

  a_out_type_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.msg_type != mcmp_pkg::MsgSystem))
    else $error("result carries a system message type");

endmodule
